>>> src/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg: shared types and constants
// Register map, reset values and the config bundles passed between the
// register file and the packet core.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mct_pkg;

  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_CURSOR_W = 3'd2,
    REG_CURSOR_H = 3'd3,
    REG_START_X  = 3'd4,
    REG_START_Y  = 3'd5,
    REG_MARGIN   = 3'd6
  } reg_idx_t;

  localparam logic [11:0] SCREEN_W_RST = 12'd1024;
  localparam logic [11:0] SCREEN_H_RST = 12'd768;
  localparam logic [7:0]  CURSOR_W_RST = 8'd16;
  localparam logic [7:0]  CURSOR_H_RST = 8'd16;
  localparam logic [11:0] START_X_RST  = 12'd0;
  localparam logic [11:0] START_Y_RST  = 12'd0;
  localparam logic [7:0]  MARGIN_RST   = 8'd5;

  // bit positions inside the first packet byte
  localparam int unsigned B0_LEFT   = 0;
  localparam int unsigned B0_RIGHT  = 1;
  localparam int unsigned B0_MIDDLE = 2;
  localparam int unsigned B0_SYNC   = 3;
  localparam int unsigned B0_XSIGN  = 4;
  localparam int unsigned B0_YSIGN  = 5;
  localparam int unsigned B0_XOVF   = 6;
  localparam int unsigned B0_YOVF   = 7;

  typedef enum logic [1:0] {
    IDX_FIRST  = 2'd0,
    IDX_SECOND = 2'd1,
    IDX_THIRD  = 2'd2
  } byte_idx_t;

  typedef struct packed {
    logic [11:0] screen_w;
    logic [11:0] screen_h;
    logic [7:0]  cursor_w;
    logic [7:0]  cursor_h;
    logic [7:0]  margin;
  } cfg_t;

  typedef struct packed {
    logic        ld_x;
    logic        ld_y;
    logic [11:0] start_x;
    logic [11:0] start_y;
  } start_ld_t;

endpackage

`default_nettype wire

>>> src/ps2_mouse_packet_cursor_tracker_unit.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_unit: PS/2 packet decoder, cursor tracker
// Usage:
//   in_* channel: one raw mouse byte per beat (valid/ready). Bytes with bit 3
//   clear are dropped until the first byte with bit 3 set; after that bytes
//   group into 3-byte packets.
//   out_* channel: one beat per completed packet with buttons, overflow
//   flags, 9-bit deltas and the clamped cursor position after the packet.
//   APB port: screen/cursor size, start position and edge margin. Writing a
//   start register also moves the cursor there. Write only while idle.
// Path: a byte is registered in the input register on accept and decoded
//   from there; the third byte's result beat is held in the result register.
// Throughput: one byte per cycle unless a held result stalls the third
//   byte; x and y add-and-clamp paths sit between input and result registers.
// Reset: sync lost, packet index cleared, registers back to defaults,
//   cursor at the default start position, no result pending.
// Stall: a held result keeps the third byte waiting in the input register;
//   bytes that produce no result keep flowing until the third byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_cursor_tracker_unit
  import ps2mct_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_BITS-1:0]    paddr,
  input  wire logic [DATA_BITS-1:0]    pwdata,
  output logic      [DATA_BITS-1:0]    prdata,
  output logic                         pready,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_data_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_left_button,
  output logic                         out_right_button,
  output logic                         out_middle_button,
  output logic                         out_x_overflow,
  output logic                         out_y_overflow,
  output logic signed [8:0]            out_delta_x,
  output logic signed [8:0]            out_delta_y,
  output logic        [COORD_BITS-1:0] out_cursor_x,
  output logic        [COORD_BITS-1:0] out_cursor_y,
  output logic                         out_cursor_moved
);

  cfg_t      cfg;
  start_ld_t start_ld;

  ps2mct_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .start_ld (start_ld)
  );

  ps2mct_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .start_ld          (start_ld),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_button   (out_left_button),
    .out_right_button  (out_right_button),
    .out_middle_button (out_middle_button),
    .out_x_overflow    (out_x_overflow),
    .out_y_overflow    (out_y_overflow),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_cursor_x      (out_cursor_x),
    .out_cursor_y      (out_cursor_y),
    .out_cursor_moved  (out_cursor_moved)
  );

endmodule

`default_nettype wire

>>> src/ps2mct_regs.sv
// ----------------------------------------------------------------------------
// ps2mct_regs: configuration register file
// APB-style write/read of the screen, cursor, start and margin registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mct_regs
  import ps2mct_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg,
  output start_ld_t                 start_ld
);

  logic [11:0] screen_w_r, screen_h_r, start_x_r, start_y_r;
  logic [7:0]  cursor_w_r, cursor_h_r, margin_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RST;
      screen_h_r <= SCREEN_H_RST;
      cursor_w_r <= CURSOR_W_RST;
      cursor_h_r <= CURSOR_H_RST;
      start_x_r  <= START_X_RST;
      start_y_r  <= START_Y_RST;
      margin_r   <= MARGIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SCREEN_W: screen_w_r <= pwdata[11:0];
        REG_SCREEN_H: screen_h_r <= pwdata[11:0];
        REG_CURSOR_W: cursor_w_r <= pwdata[7:0];
        REG_CURSOR_H: cursor_h_r <= pwdata[7:0];
        REG_START_X:  start_x_r  <= pwdata[11:0];
        REG_START_Y:  start_y_r  <= pwdata[11:0];
        REG_MARGIN:   margin_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCREEN_W: prdata = DATA_BITS'(screen_w_r);
      REG_SCREEN_H: prdata = DATA_BITS'(screen_h_r);
      REG_CURSOR_W: prdata = DATA_BITS'(cursor_w_r);
      REG_CURSOR_H: prdata = DATA_BITS'(cursor_h_r);
      REG_START_X:  prdata = DATA_BITS'(start_x_r);
      REG_START_Y:  prdata = DATA_BITS'(start_y_r);
      REG_MARGIN:   prdata = DATA_BITS'(margin_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.screen_w = screen_w_r;
  assign cfg.screen_h = screen_h_r;
  assign cfg.cursor_w = cursor_w_r;
  assign cfg.cursor_h = cursor_h_r;
  assign cfg.margin   = margin_r;

  // start writes also load the live cursor position
  assign start_ld.ld_x    = wr_en && (idx == REG_START_X);
  assign start_ld.ld_y    = wr_en && (idx == REG_START_Y);
  assign start_ld.start_x = pwdata[11:0];
  assign start_ld.start_y = pwdata[11:0];

endmodule

`default_nettype wire

>>> src/ps2mct_clamp.sv
// ----------------------------------------------------------------------------
// ps2mct_clamp: one-axis screen clamp
// Pulls a moved coordinate back inside the screen with a margin, then
// saturates it to the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mct_clamp #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic signed [COORD_BITS+2:0] pos_in,
  input  wire logic        [7:0]            size,
  input  wire logic        [11:0]           screen,
  input  wire logic        [7:0]            margin,
  output logic             [COORD_BITS-1:0] pos_out
);

  localparam int unsigned CW = COORD_BITS + 3;
  localparam logic signed [CW-1:0] MAX_S = CW'((1 << COORD_BITS) - 1);

  logic signed [CW-1:0] size_s, scr_s, mar_s, far_edge, clamped;

  assign size_s   = $signed(CW'(size));
  assign scr_s    = $signed(CW'(screen));
  assign mar_s    = $signed(CW'(margin));
  assign far_edge = scr_s - size_s - mar_s;

  always_comb begin
    if (pos_in + size_s > scr_s) begin
      clamped = far_edge;
    end else if (pos_in < 0) begin
      clamped = mar_s;
    end else begin
      clamped = pos_in;
    end
    if (clamped < 0) begin
      pos_out = '0;
    end else if (clamped > MAX_S) begin
      pos_out = MAX_S[COORD_BITS-1:0];
    end else begin
      pos_out = clamped[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/ps2mct_core.sv
// ----------------------------------------------------------------------------
// ps2mct_core: packet assembly and cursor update
// Input register, sync and byte-index tracking, delta decode, cursor
// position registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mct_core
  import ps2mct_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire start_ld_t              start_ld,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_data_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_left_button,
  output logic                        out_right_button,
  output logic                        out_middle_button,
  output logic                        out_x_overflow,
  output logic                        out_y_overflow,
  output logic signed [8:0]           out_delta_x,
  output logic signed [8:0]           out_delta_y,
  output logic        [COORD_BITS-1:0] out_cursor_x,
  output logic        [COORD_BITS-1:0] out_cursor_y,
  output logic                        out_cursor_moved
);

  localparam int unsigned CW = COORD_BITS + 3;

  logic                  in_v_r;
  logic [7:0]            in_byte_r;
  logic                  synced_r;
  byte_idx_t             idx_r;
  logic [7:0]            first_r, second_r;
  logic [COORD_BITS-1:0] pos_x_r, pos_y_r;
  logic [COORD_BITS-1:0] pos_x_nxt, pos_y_nxt, clamp_x, clamp_y;

  logic                  out_v_r;
  logic [7:0]            out_first_r;
  logic signed [8:0]     out_dx_r, out_dy_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                  out_moved_r;

  logic                  drop, is_third, out_free, go, out_load, moved;
  logic signed [8:0]     dx, dy;
  logic signed [CW-1:0]  px, py;

  assign drop     = !synced_r && !in_byte_r[B0_SYNC];
  assign is_third = !drop && (idx_r == IDX_THIRD);
  assign out_free = !out_v_r || out_ready;
  assign go       = in_v_r && (!is_third || out_free);
  assign out_load = go && is_third;
  assign in_ready = !in_v_r || go;

  assign dx    = $signed({first_r[B0_XSIGN], second_r});
  assign dy    = $signed({first_r[B0_YSIGN], in_byte_r});
  assign moved = !(first_r[B0_XOVF] || first_r[B0_YOVF]);

  // x moves right with dx, y moves down against dy
  assign px = $signed(CW'(pos_x_r)) + {{(CW-9){dx[8]}}, dx};
  assign py = $signed(CW'(pos_y_r)) - {{(CW-9){dy[8]}}, dy};

  ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .pos_in  (px),
    .size    (cfg.cursor_w),
    .screen  (cfg.screen_w),
    .margin  (cfg.margin),
    .pos_out (clamp_x)
  );

  ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .pos_in  (py),
    .size    (cfg.cursor_h),
    .screen  (cfg.screen_h),
    .margin  (cfg.margin),
    .pos_out (clamp_y)
  );

  assign pos_x_nxt = moved ? clamp_x : pos_x_r;
  assign pos_y_nxt = moved ? clamp_y : pos_y_r;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      synced_r <= 1'b0;
      idx_r    <= IDX_FIRST;
      first_r  <= '0;
      second_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (go && !drop) begin
        synced_r <= 1'b1;
        case (idx_r)
          IDX_SECOND: begin
            second_r <= in_byte_r;
            idx_r    <= IDX_THIRD;
          end
          IDX_THIRD: begin
            idx_r <= IDX_FIRST;
          end
          default: begin
            first_r <= in_byte_r;
            idx_r   <= IDX_SECOND;
          end
        endcase
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= COORD_BITS'(START_X_RST);
      pos_y_r <= COORD_BITS'(START_Y_RST);
    end else begin
      if (start_ld.ld_x) begin
        pos_x_r <= COORD_BITS'(start_ld.start_x);
      end else if (out_load) begin
        pos_x_r <= pos_x_nxt;
      end
      if (start_ld.ld_y) begin
        pos_y_r <= COORD_BITS'(start_ld.start_y);
      end else if (out_load) begin
        pos_y_r <= pos_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_first_r <= first_r;
      out_dx_r    <= dx;
      out_dy_r    <= dy;
      out_x_r     <= pos_x_nxt;
      out_y_r     <= pos_y_nxt;
      out_moved_r <= moved;
    end
  end

  assign out_valid         = out_v_r;
  assign out_left_button   = out_first_r[B0_LEFT];
  assign out_right_button  = out_first_r[B0_RIGHT];
  assign out_middle_button = out_first_r[B0_MIDDLE];
  assign out_x_overflow    = out_first_r[B0_XOVF];
  assign out_y_overflow    = out_first_r[B0_YOVF];
  assign out_delta_x       = out_dx_r;
  assign out_delta_y       = out_dy_r;
  assign out_cursor_x      = out_x_r;
  assign out_cursor_y      = out_y_r;
  assign out_cursor_moved  = out_moved_r;

`ifndef SYNTHESIS
  a_idx_legal: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r == IDX_FIRST || idx_r == IDX_SECOND || idx_r == IDX_THIRD)
    else $error("byte index left the three-byte cycle");

  a_unsynced_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !synced_r |-> idx_r == IDX_FIRST)
    else $error("packet progress before sync");

  a_load_third: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> synced_r && idx_r == IDX_THIRD && out_free)
    else $error("result loaded outside third byte or over a pending beat");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !go |=> in_v_r && $stable(in_byte_r))
    else $error("stalled input byte lost");
`endif

endmodule

`default_nettype wire
